// File: rtl/dcd_pkg.sv
// shared types, codes and helpers of the debug command decoder
`default_nettype none

package dcd_pkg;

    localparam int REG_BYTES = 64;
    localparam int ADDR_BITS = 32;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_CMD,
        PH_ADDR,
        PH_LEN,
        PH_DATA,
        PH_ZTYPE,
        PH_ZCOMMA,
        PH_SKIP
    } dcd_phase_t;

    typedef enum logic [3:0] {
        K_QUERY,
        K_TOGGLE,
        K_RREGS,
        K_WREGS,
        K_RMEM,
        K_WMEM,
        K_CONT,
        K_STEP,
        K_KILL,
        K_ADDBRK,
        K_DELBRK,
        K_DELALL,
        K_UNKNOWN
    } dcd_kind_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_MALFORMED,
        ST_BAD_WRITE,
        ST_BAD_TYPE
    } dcd_status_t;

    typedef struct packed {
        dcd_kind_t   kind;
        logic [31:0] address;
        logic [31:0] length;
        logic        address_present;
        dcd_status_t status;
        logic [7:0]  data_byte;
        logic        is_data;
        logic        done;
    } dcd_result_t;

    typedef struct packed {
        logic        data_valid;
        logic        sum_valid;
        dcd_result_t data_res;
        dcd_result_t sum_res;
    } dcd_push_t;

    // bit 4 set when the character is a hex digit, low bits hold its value
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= 8'h61 && ch <= 8'h66)
            r = {1'b1, 4'(ch - 8'h57)};
        else if (ch >= 8'h30 && ch <= 8'h39)
            r = {1'b1, 4'(ch - 8'h30)};
        else if (ch >= 8'h41 && ch <= 8'h46)
            r = {1'b1, 4'(ch - 8'h37)};
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/dcd_parser.sv
// per-character parse state and result generation
`default_nettype none

module dcd_parser
    import dcd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] char_in,
    input  wire logic       last_char,
    output dcd_push_t       push
);

    localparam logic [7:0] CH_QUERY  = 8'h3f;
    localparam logic [7:0] CH_TOGGLE = 8'h64;
    localparam logic [7:0] CH_KILL   = 8'h6b;
    localparam logic [7:0] CH_RREGS  = 8'h67;
    localparam logic [7:0] CH_WREGS  = 8'h47;
    localparam logic [7:0] CH_RMEM   = 8'h6d;
    localparam logic [7:0] CH_WMEM   = 8'h4d;
    localparam logic [7:0] CH_CONT   = 8'h63;
    localparam logic [7:0] CH_STEP   = 8'h73;
    localparam logic [7:0] CH_ADDBRK = 8'h5a;
    localparam logic [7:0] CH_DELBRK = 8'h7a;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_COLON  = 8'h3a;

    dcd_phase_t             phase_reg, phase_step, phase_next;
    dcd_kind_t              kind_reg, kind_step, kind_next;
    logic [ADDR_BITS-1:0]   address_reg, address_step, address_next;
    logic [31:0]            length_reg, length_step, length_next;
    logic                   digit_seen_reg, digit_seen_step, digit_seen_next;
    logic                   len_seen_reg, len_seen_step, len_seen_next;
    logic [3:0]             high_nibble_reg, high_nibble_step, high_nibble_next;
    logic                   pending_reg, pending_step, pending_next;
    logic [31:0]            bytes_reg, bytes_step, bytes_next;
    dcd_status_t            error_reg, error_step, error_next;

    logic [4:0]             hex;
    logic                   is_hex;
    logic [7:0]             nib_val;
    logic                   data_out;
    logic [7:0]             data_byte;
    logic                   brk;
    dcd_status_t            final_status;

    assign hex     = hex_decode(char_in);
    assign is_hex  = hex[4];
    assign nib_val = is_hex ? {4'd0, hex[3:0]} : 8'hff;
    assign brk     = (kind_reg == K_ADDBRK) || (kind_reg == K_DELBRK);

    // one character of parsing
    always_comb
    begin
        phase_step       = phase_reg;
        kind_step        = kind_reg;
        address_step     = address_reg;
        length_step      = length_reg;
        digit_seen_step  = digit_seen_reg;
        len_seen_step    = len_seen_reg;
        high_nibble_step = high_nibble_reg;
        pending_step     = pending_reg;
        bytes_step       = bytes_reg;
        error_step       = error_reg;
        data_out         = 1'b0;
        data_byte        = 8'd0;
        unique case (phase_reg)
            PH_CMD:
            begin
                phase_step = PH_SKIP;
                error_step = ST_OK;
                unique case (char_in)
                    CH_QUERY:  kind_step = K_QUERY;
                    CH_TOGGLE: kind_step = K_TOGGLE;
                    CH_KILL:   kind_step = K_KILL;
                    CH_RREGS:
                    begin
                        kind_step   = K_RREGS;
                        length_step = 32'(REG_BYTES);
                    end
                    CH_WREGS:
                    begin
                        kind_step   = K_WREGS;
                        length_step = 32'(REG_BYTES);
                        phase_step  = PH_DATA;
                    end
                    CH_RMEM:
                    begin
                        kind_step  = K_RMEM;
                        phase_step = PH_ADDR;
                    end
                    CH_WMEM:
                    begin
                        kind_step  = K_WMEM;
                        phase_step = PH_ADDR;
                    end
                    CH_CONT:
                    begin
                        kind_step  = K_CONT;
                        phase_step = PH_ADDR;
                    end
                    CH_STEP:
                    begin
                        kind_step  = K_STEP;
                        phase_step = PH_ADDR;
                    end
                    CH_ADDBRK:
                    begin
                        kind_step  = K_ADDBRK;
                        phase_step = PH_ZTYPE;
                    end
                    CH_DELBRK:
                    begin
                        kind_step  = K_DELBRK;
                        phase_step = PH_ZTYPE;
                    end
                    default:   kind_step = K_UNKNOWN;
                endcase
            end
            PH_ADDR:
            begin
                priority if (is_hex)
                begin
                    address_step    = {address_reg[ADDR_BITS-5:0], hex[3:0]};
                    digit_seen_step = 1'b1;
                end
                else if (kind_reg == K_CONT || kind_reg == K_STEP)
                begin
                    phase_step = PH_SKIP;
                    error_step = ST_OK;
                end
                else if (digit_seen_reg && char_in == CH_COMMA)
                    phase_step = PH_LEN;
                else
                begin
                    phase_step = PH_SKIP;
                    error_step = (kind_reg == K_WMEM) ? ST_BAD_WRITE : ST_MALFORMED;
                end
            end
            PH_LEN:
            begin
                priority if (is_hex)
                begin
                    length_step   = {length_reg[27:0], hex[3:0]};
                    len_seen_step = 1'b1;
                end
                else if (kind_reg == K_RMEM)
                begin
                    phase_step = PH_SKIP;
                    error_step = len_seen_reg ? ST_OK : ST_MALFORMED;
                end
                else if (kind_reg == K_WMEM)
                begin
                    if (len_seen_reg && char_in == CH_COLON)
                        phase_step = PH_DATA;
                    else
                    begin
                        phase_step = PH_SKIP;
                        error_step = ST_BAD_WRITE;
                    end
                end
                else if (brk && len_seen_reg)
                begin
                    phase_step = PH_SKIP;
                    error_step = (length_reg == 32'd1) ? ST_OK : ST_BAD_WRITE;
                end
                else
                begin
                    phase_step = PH_SKIP;
                    error_step = ST_MALFORMED;
                end
            end
            PH_DATA:
            begin
                if (bytes_reg < length_reg)
                begin
                    if (!pending_reg)
                    begin
                        high_nibble_step = nib_val[3:0];
                        pending_step     = 1'b1;
                    end
                    else
                    begin
                        pending_step = 1'b0;
                        bytes_step   = bytes_reg + 32'd1;
                        data_out     = 1'b1;
                        data_byte    = {high_nibble_reg, 4'd0} + nib_val;
                    end
                end
            end
            PH_ZTYPE:
            begin
                priority if (char_in == CH_DELBRK && kind_reg == K_DELBRK)
                begin
                    kind_step  = K_DELALL;
                    phase_step = PH_SKIP;
                    error_step = ST_OK;
                end
                else if (is_hex && hex[3:0] == 4'd0)
                    phase_step = PH_ZCOMMA;
                else
                begin
                    phase_step = PH_SKIP;
                    error_step = ST_BAD_TYPE;
                end
            end
            PH_ZCOMMA:
            begin
                if (char_in == CH_COMMA)
                    phase_step = PH_ADDR;
                else
                begin
                    phase_step = PH_SKIP;
                    error_step = ST_MALFORMED;
                end
            end
            default:
            begin
            end
        endcase
    end

    // packet status from the state left by the final character
    always_comb
    begin
        final_status = ST_OK;
        unique case (phase_step)
            PH_ADDR:
            begin
                priority if (kind_step == K_CONT || kind_step == K_STEP)
                    final_status = ST_OK;
                else if (kind_step == K_WMEM)
                    final_status = ST_BAD_WRITE;
                else
                    final_status = ST_MALFORMED;
            end
            PH_LEN:
            begin
                priority if (kind_step == K_RMEM)
                    final_status = len_seen_step ? ST_OK : ST_MALFORMED;
                else if (kind_step == K_WMEM)
                    final_status = ST_BAD_WRITE;
                else if (!len_seen_step)
                    final_status = ST_MALFORMED;
                else
                    final_status = (length_step == 32'd1) ? ST_OK : ST_BAD_WRITE;
            end
            PH_ZTYPE:  final_status = ST_BAD_TYPE;
            PH_ZCOMMA: final_status = ST_MALFORMED;
            PH_SKIP:   final_status = error_step;
            default:   final_status = ST_OK;
        endcase
    end

    // results of the accepted transaction
    always_comb
    begin
        push.data_valid               = accept && data_out;
        push.sum_valid                = accept && last_char;
        push.data_res.kind            = kind_step;
        push.data_res.address         = 32'(address_step);
        push.data_res.length          = length_step;
        push.data_res.address_present = digit_seen_step;
        push.data_res.status          = ST_OK;
        push.data_res.data_byte       = data_byte;
        push.data_res.is_data         = 1'b1;
        push.data_res.done            = 1'b0;
        push.sum_res.kind             = kind_step;
        push.sum_res.address          = 32'(address_step);
        push.sum_res.length           = length_step;
        push.sum_res.address_present  = digit_seen_step;
        push.sum_res.status           = final_status;
        push.sum_res.data_byte        = 8'd0;
        push.sum_res.is_data          = 1'b0;
        push.sum_res.done             = 1'b1;
    end

    // next state: back to the command letter after each packet
    always_comb
    begin
        phase_next       = phase_reg;
        kind_next        = kind_reg;
        address_next     = address_reg;
        length_next      = length_reg;
        digit_seen_next  = digit_seen_reg;
        len_seen_next    = len_seen_reg;
        high_nibble_next = high_nibble_reg;
        pending_next     = pending_reg;
        bytes_next       = bytes_reg;
        error_next       = error_reg;
        if (accept && last_char)
        begin
            phase_next       = PH_CMD;
            kind_next        = K_QUERY;
            address_next     = '0;
            length_next      = 32'd0;
            digit_seen_next  = 1'b0;
            len_seen_next    = 1'b0;
            high_nibble_next = 4'd0;
            pending_next     = 1'b0;
            bytes_next       = 32'd0;
            error_next       = ST_OK;
        end
        else if (accept)
        begin
            phase_next       = phase_step;
            kind_next        = kind_step;
            address_next     = address_step;
            length_next      = length_step;
            digit_seen_next  = digit_seen_step;
            len_seen_next    = len_seen_step;
            high_nibble_next = high_nibble_step;
            pending_next     = pending_step;
            bytes_next       = bytes_step;
            error_next       = error_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_CMD;
            kind_reg        <= K_QUERY;
            address_reg     <= '0;
            length_reg      <= 32'd0;
            digit_seen_reg  <= 1'b0;
            len_seen_reg    <= 1'b0;
            high_nibble_reg <= 4'd0;
            pending_reg     <= 1'b0;
            bytes_reg       <= 32'd0;
            error_reg       <= ST_OK;
        end
        else
        begin
            phase_reg       <= phase_next;
            kind_reg        <= kind_next;
            address_reg     <= address_next;
            length_reg      <= length_next;
            digit_seen_reg  <= digit_seen_next;
            len_seen_reg    <= len_seen_next;
            high_nibble_reg <= high_nibble_next;
            pending_reg     <= pending_next;
            bytes_reg       <= bytes_next;
            error_reg       <= error_next;
        end
    end

    a_back_to_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_char |=> phase_reg == PH_CMD && !pending_reg)
        else $error("parser did not return to command letter after packet end");

    a_data_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
        push.data_valid |-> phase_reg == PH_DATA && pending_reg)
        else $error("data byte produced outside a data pair");

    a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_reg <= length_reg)
        else $error("more data bytes emitted than the length allows");

endmodule

`default_nettype wire

// File: rtl/dcd_out_queue.sv
// small result queue taking up to two results per transaction
`default_nettype none

module dcd_out_queue
    import dcd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire dcd_push_t push,
    output logic       space_ok,
    output logic       out_valid,
    input  wire logic  out_ready,
    output dcd_result_t out_res
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = PTR_BITS + 1;

    dcd_result_t          mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [CNT_BITS-1:0]  n_push;
    logic                 pop;

    assign n_push    = CNT_BITS'(push.data_valid) + CNT_BITS'(push.sum_valid);
    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign out_res   = mem[rd_ptr_reg];
    assign space_ok  = count_reg <= CNT_BITS'(QUEUE_DEPTH - 2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(n_push);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + n_push - CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.data_valid)
            mem[wr_ptr_reg] <= push.data_res;
        if (push.sum_valid && push.data_valid)
            mem[wr_ptr_reg + PTR_BITS'(1)] <= push.sum_res;
        else if (push.sum_valid)
            mem[wr_ptr_reg] <= push.sum_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/debug_command_decoder.sv
// top level of the debug command decoder
// Takes one payload character of a debugger command packet per transaction on s_axis,
// with tlast on the final character, and can take one every cycle while s_axis_tready is
// high. Data bytes of register and memory writes appear on m_axis with tuser set; the
// packet summary (class, address, length, address presence, status) follows with tlast
// set. A result is written into the queue when its character is taken. Results wait in a
// four-entry queue; s_axis_tready stays high while at most two results are waiting, so a
// stalled m_axis side holds the input back once three results are queued.
`default_nettype none

module debug_command_decoder
    import dcd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // char_in
    input  wire logic        s_axis_tlast,   // last_char
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,   // command_kind, address, length,
                                             // address_present, status, data_byte, pad
    output logic             m_axis_tuser,   // is_data
    output logic             m_axis_tlast    // done_res
);

    dcd_push_t   push;
    dcd_result_t out_res;
    logic        accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    dcd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_in   (s_axis_tdata),
        .last_char (s_axis_tlast),
        .push      (push)
    );

    dcd_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {1'b0, out_res.data_byte, out_res.status,
                           out_res.address_present, out_res.length,
                           out_res.address, out_res.kind};
    assign m_axis_tuser = out_res.is_data;
    assign m_axis_tlast = out_res.done;

endmodule

`default_nettype wire

// File: bench/dcd_checker.sv
// result checker for the debug command decoder: predicts each transaction and compares
`timescale 1ns / 100ps

module dcd_checker
    import dcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          outstanding,
    output int          checked_count
);

    dcd_phase_t  phase;
    dcd_kind_t   kind;
    logic [31:0] addr_acc;
    logic [31:0] len_acc;
    logic [31:0] bytes_done;
    logic        addr_seen;
    logic        len_seen;
    logic        nib_pending;
    logic [4:0]  hi_nib;
    dcd_status_t skip_status;

    dcd_result_t expected_results[$];
    int fails = 0;
    int checked = 0;

    function automatic int char_nibble(input logic [7:0] ch);
        if (ch >= "a" && ch <= "f")
            return int'(ch) - int'("a") + 10;
        if (ch >= "0" && ch <= "9")
            return int'(ch) - int'("0");
        if (ch >= "A" && ch <= "F")
            return int'(ch) - int'("A") + 10;
        return -1;
    endfunction

    function automatic void clear_state();
        phase = PH_CMD;
        kind = K_QUERY;
        addr_acc = '0;
        len_acc = '0;
        bytes_done = '0;
        addr_seen = 1'b0;
        len_seen = 1'b0;
        nib_pending = 1'b0;
        hi_nib = '0;
        skip_status = ST_OK;
    endfunction

    function automatic dcd_result_t make_result(input dcd_status_t st, input logic [7:0] b,
                                                input logic isd, input logic done);
        dcd_result_t r;
        r.kind = kind;
        r.address = addr_acc;
        r.length = len_acc;
        r.address_present = addr_seen;
        r.status = st;
        r.data_byte = b;
        r.is_data = isd;
        r.done = done;
        return r;
    endfunction

    function automatic void go_skip(input dcd_status_t st);
        skip_status = st;
        phase = PH_SKIP;
    endfunction

    // status reported when the packet ends in the current phase
    function automatic dcd_status_t end_status();
        case (phase)
            PH_ADDR:
            begin
                if (kind == K_CONT || kind == K_STEP)
                    return ST_OK;
                return (kind == K_WMEM) ? ST_BAD_WRITE : ST_MALFORMED;
            end
            PH_LEN:
            begin
                if (kind == K_RMEM)
                    return len_seen ? ST_OK : ST_MALFORMED;
                if (kind == K_WMEM)
                    return ST_BAD_WRITE;
                if (!len_seen)
                    return ST_MALFORMED;
                return (len_acc == 32'd1) ? ST_OK : ST_BAD_WRITE;
            end
            PH_ZTYPE:  return ST_BAD_TYPE;
            PH_ZCOMMA: return ST_MALFORMED;
            PH_SKIP:   return skip_status;
            default:   return ST_OK;
        endcase
    endfunction

    function automatic void start_command(input logic [7:0] c);
        case (c)
            "?":
            begin
                kind = K_QUERY;
                go_skip(ST_OK);
            end
            "d":
            begin
                kind = K_TOGGLE;
                go_skip(ST_OK);
            end
            "k":
            begin
                kind = K_KILL;
                go_skip(ST_OK);
            end
            "g":
            begin
                kind = K_RREGS;
                len_acc = 32'(REG_BYTES);
                go_skip(ST_OK);
            end
            "G":
            begin
                kind = K_WREGS;
                len_acc = 32'(REG_BYTES);
                phase = PH_DATA;
            end
            "m":
            begin
                kind = K_RMEM;
                phase = PH_ADDR;
            end
            "M":
            begin
                kind = K_WMEM;
                phase = PH_ADDR;
            end
            "c":
            begin
                kind = K_CONT;
                phase = PH_ADDR;
            end
            "s":
            begin
                kind = K_STEP;
                phase = PH_ADDR;
            end
            "Z":
            begin
                kind = K_ADDBRK;
                phase = PH_ZTYPE;
            end
            "z":
            begin
                kind = K_DELBRK;
                phase = PH_ZTYPE;
            end
            default:
            begin
                kind = K_UNKNOWN;
                go_skip(ST_OK);
            end
        endcase
    endfunction

    function automatic void predict_char(input logic [7:0] c, input logic last);
        int h;
        int v;
        logic brk;
        h = char_nibble(c);
        brk = (kind == K_ADDBRK || kind == K_DELBRK);
        case (phase)
            PH_CMD:
                start_command(c);
            PH_ADDR:
            begin
                if (h >= 0)
                begin
                    addr_acc = {addr_acc[27:0], 4'(h)};
                    addr_seen = 1'b1;
                end
                else if (kind == K_CONT || kind == K_STEP)
                    go_skip(ST_OK);
                else if (addr_seen && c == ",")
                    phase = PH_LEN;
                else
                    go_skip((kind == K_WMEM) ? ST_BAD_WRITE : ST_MALFORMED);
            end
            PH_LEN:
            begin
                if (h >= 0)
                begin
                    len_acc = {len_acc[27:0], 4'(h)};
                    len_seen = 1'b1;
                end
                else if (kind == K_RMEM)
                    go_skip(len_seen ? ST_OK : ST_MALFORMED);
                else if (kind == K_WMEM)
                begin
                    if (len_seen && c == ":")
                        phase = PH_DATA;
                    else
                        go_skip(ST_BAD_WRITE);
                end
                else if (brk && len_seen)
                    go_skip((len_acc == 32'd1) ? ST_OK : ST_BAD_WRITE);
                else
                    go_skip(ST_MALFORMED);
            end
            PH_DATA:
            begin
                // a non-hex character stands for the nibble -1
                if (bytes_done < len_acc)
                begin
                    v = (h < 0) ? 255 : h;
                    if (!nib_pending)
                    begin
                        hi_nib = 5'(v);
                        nib_pending = 1'b1;
                    end
                    else
                    begin
                        nib_pending = 1'b0;
                        bytes_done = bytes_done + 32'd1;
                        expected_results.push_back(
                            make_result(ST_OK, 8'((int'(hi_nib) << 4) + v), 1'b1, 1'b0));
                    end
                end
            end
            PH_ZTYPE:
            begin
                if (c == "z" && kind == K_DELBRK)
                begin
                    kind = K_DELALL;
                    go_skip(ST_OK);
                end
                else if (h == 0)
                    phase = PH_ZCOMMA;
                else
                    go_skip(ST_BAD_TYPE);
            end
            PH_ZCOMMA:
            begin
                if (c == ",")
                    phase = PH_ADDR;
                else
                    go_skip(ST_MALFORMED);
            end
            default:
            begin
            end
        endcase
        if (last)
        begin
            expected_results.push_back(make_result(end_status(), 8'h00, 1'b0, 1'b1));
            clear_state();
        end
    endfunction

    function automatic string describe(input dcd_result_t r);
        return $sformatf("kind %0d addr %h len %h present %b status %0d byte %h data %b done %b",
                         r.kind, r.address, r.length, r.address_present, r.status,
                         r.data_byte, r.is_data, r.done);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        dcd_result_t seen;
        dcd_result_t want;
        if (!rst_n)
        begin
            clear_state();
            expected_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.kind = dcd_kind_t'(m_tdata[3:0]);
                seen.address = m_tdata[35:4];
                seen.length = m_tdata[67:36];
                seen.address_present = m_tdata[68];
                seen.status = dcd_status_t'(m_tdata[70:69]);
                seen.data_byte = m_tdata[78:71];
                seen.is_data = m_tuser;
                seen.done = m_tlast;
                checked++;
                if (expected_results.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result %0d: %s", checked, describe(seen));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (seen !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display("mismatch on result %0d", checked);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(seen));
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_char(s_tdata, s_tlast);
        end
        fail_count <= fails;
        outstanding <= expected_results.size();
        checked_count <= checked;
    end

endmodule

// File: bench/tb_debug_command_decoder.sv
// testbench top of the debug command decoder: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_debug_command_decoder
    import dcd_pkg::*;
();

    localparam int CHAR_TARGET = 650;
    localparam int IDLE_LIMIT = 1000;
    localparam int HOLD_AT = 40;
    localparam int HOLD_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire [79:0]  m_axis_tdata;
    wire         m_axis_tuser;
    wire         m_axis_tlast;

    int fail_count;
    int outstanding;
    int checked_count;
    int chars_sent = 0;
    int packets_sent = 0;
    int results_taken = 0;
    int idle_cycles = 0;
    logic burst = 1'b0;
    logic [7:0] pkt[$];

    always #5 clk = ~clk;

    debug_command_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    dcd_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_axis_tvalid),
        .s_tready      (s_axis_tready),
        .s_tdata       (s_axis_tdata),
        .s_tlast       (s_axis_tlast),
        .m_tvalid      (m_axis_tvalid),
        .m_tready      (m_axis_tready),
        .m_tdata       (m_axis_tdata),
        .m_tuser       (m_axis_tuser),
        .m_tlast       (m_axis_tlast),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count)
    );

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return "0" + 8'(nib);
        return ($urandom_range(0, 1) ? "a" : "A") + 8'(nib) - 8'd10;
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            pkt.push_back(s[i]);
    endfunction

    function automatic void add_digits(input int n);
        repeat (n) pkt.push_back(hex_char(4'($urandom)));
    endfunction

    // hex text of a value, random case, sometimes a leading zero
    function automatic void add_value(input logic [31:0] v);
        int n;
        n = 8;
        while (n > 1 && v[4*n-1 -: 4] == 4'h0)
            n--;
        if ($urandom_range(0, 3) == 0)
            pkt.push_back("0");
        for (int i = n - 1; i >= 0; i--)
            pkt.push_back(hex_char(v[4*i +: 4]));
    endfunction

    function automatic void add_address();
        case ($urandom_range(0, 4))
            0: add_value(32'h0000_0000);
            1: add_value(32'hffff_ffff);
            2: add_digits($urandom_range(9, 12));
            default: add_value($urandom);
        endcase
    endfunction

    function automatic void add_data(input int n);
        repeat (n)
        begin
            if ($urandom_range(0, 23) == 0)
                pkt.push_back(8'($urandom));
            else
                pkt.push_back(hex_char(4'($urandom)));
        end
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        chars_sent++;
        gap = burst ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++)
            send_char(pkt[i], i == pkt.size() - 1);
        pkt.delete();
        packets_sent++;
    endtask

    initial
    begin : stimulus
        logic [31:0] len;
        int pairs;
        int big_g_left;
        int pick;
        big_g_left = 2;
        while (!rst_n)
            @(posedge clk);
        @(posedge clk);

        // directed: every class, remove-all, bad type, non-hex data
        add_text("?");
        send_packet();
        add_text("d");
        send_packet();
        add_text("k");
        send_packet();
        add_text("g");
        send_packet();
        pkt.push_back(8'hff);
        send_packet();
        add_text("c");
        send_packet();
        add_text("s7");
        send_packet();
        add_text("zz");
        send_packet();
        add_text("Z0,a,1");
        send_packet();
        add_text("z3");
        send_packet();
        add_text("mF,2");
        send_packet();
        add_text("M0,1:g0");
        send_packet();
        add_text("G");
        send_packet();

        while (chars_sent < CHAR_TARGET)
        begin
            burst = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
            end
            else if (pick < 15)
            begin
                case ($urandom_range(0, 4))
                    0: pkt.push_back("?");
                    1: pkt.push_back("d");
                    2: pkt.push_back("k");
                    3: pkt.push_back("g");
                    default: pkt.push_back(8'($urandom));
                endcase
                repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
            end
            else if (pick < 25)
            begin
                pkt.push_back("G");
                if (big_g_left > 0 && $urandom_range(0, 2) == 0)
                begin
                    big_g_left--;
                    pairs = $urandom_range(REG_BYTES - 2, REG_BYTES + 2);
                end
                else
                    pairs = $urandom_range(0, 6);
                add_data(2 * pairs + ($urandom_range(0, 4) == 0 ? 1 : 0));
            end
            else if (pick < 40)
            begin
                pkt.push_back("m");
                add_address();
                pkt.push_back(",");
                add_value($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 255));
                if ($urandom_range(0, 3) == 0)
                    pkt.push_back(8'($urandom));
            end
            else if (pick < 60)
            begin
                pkt.push_back("M");
                add_address();
                pkt.push_back(",");
                len = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
                add_value(len);
                pkt.push_back(":");
                if (len > 32'd8)
                    pairs = $urandom_range(0, 4);
                else if ($urandom_range(0, 3) == 0)
                    pairs = $urandom_range(0, int'(len) + 2);
                else
                    pairs = int'(len);
                add_data(2 * pairs + ($urandom_range(0, 5) == 0 ? 1 : 0));
            end
            else if (pick < 70)
            begin
                pkt.push_back($urandom_range(0, 1) ? "c" : "s");
                if ($urandom_range(0, 3) != 0)
                    add_address();
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
            end
            else if (pick < 90)
            begin
                pkt.push_back($urandom_range(0, 1) ? "Z" : "z");
                case ($urandom_range(0, 9))
                    0: pkt.push_back(hex_char(4'($urandom_range(1, 15))));
                    1: ;
                    default: pkt.push_back("0");
                endcase
                pkt.push_back(",");
                add_address();
                pkt.push_back(",");
                if ($urandom_range(0, 2) != 0)
                    add_value(32'd1);
                else
                    add_value($urandom_range(0, 1) ? $urandom : $urandom_range(0, 3));
                case ($urandom_range(0, 2))
                    0: ;
                    1: add_text(",1");
                    default: pkt.push_back(8'($urandom));
                endcase
            end
            else
            begin
                add_text("zz");
                repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
            end
            // broken packets: a corrupted character or a cut-off tail
            if (pkt.size() > 1 && $urandom_range(0, 6) == 0)
            begin
                if ($urandom_range(0, 1))
                    pkt[$urandom_range(1, pkt.size() - 1)] = 8'($urandom);
                else
                begin
                    pairs = $urandom_range(1, pkt.size() - 1);
                    while (pkt.size() > pairs)
                        void'(pkt.pop_back());
                end
            end
            send_packet();
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("run covered %0d packets, %0d characters, %0d results checked",
                 packets_sent, chars_sent, checked_count);
        $display("mismatches %0d, results still awaited %0d", fail_count, outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stalls, stall-free stretches and one long hold-off
    initial
    begin : sink
        int stall;
        logic rx_burst;
        logic held;
        rx_burst = 1'b0;
        held = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (results_taken % 16 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            stall = rx_burst ? 0 : $urandom_range(0, 12);
            if (!held && results_taken >= HOLD_AT)
            begin
                stall = HOLD_CYCLES;
                held = 1'b1;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            results_taken++;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// File: debug_command_decoder.f
rtl/dcd_pkg.sv
rtl/dcd_parser.sv
rtl/dcd_out_queue.sv
rtl/debug_command_decoder.sv
bench/dcd_checker.sv
bench/tb_debug_command_decoder.sv
